### hw/rtl/hash_bitmap_mark_insert_core_assert.svh
// assertion macros shared by the checker files
`ifndef HASH_BITMAP_MARK_INSERT_CORE_ASSERT_SVH
`define HASH_BITMAP_MARK_INSERT_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define HBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define HBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/hbm_pkg.sv
// types, codes and helpers of the hash bitmap mark/insert block
package hbm_pkg;

  localparam logic [63:0] GOLD_A = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] GOLD_B = 64'h9e3779b97f4a7c15;

  localparam int WORDS_W = 12;

  localparam logic OP_MARK = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_FILLED  = 2'd1;
  localparam logic [1:0] SLOT_CLAIMED = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] CFG_HASH_LOG2 = 2'd0;
  localparam logic [1:0] CFG_RESERVE   = 2'd1;

  typedef struct packed {
    logic        op;
    logic [23:0] cell_id;
    logic [63:0] key_value;
    logic [15:0] bit_rank;
    logic [16:0] bitmap_bits;
    logic [15:0] read_address;
  } req_t;

  // effective table bits: zero acts as one, above the maximum acts as the maximum
  function automatic logic [4:0] table_bits(input logic [3:0] v, input logic [4:0] maxb);
    logic [4:0] r;
    if (v == 4'd0) r = 5'd1;
    else if ({1'b0, v} > maxb) r = maxb;
    else r = {1'b0, v};
    return r;
  endfunction

endpackage

### hw/rtl/hash_bitmap_mark_insert_core.sv
// top level of the hash bitmap mark/insert block
// hash bitmap mark/insert: an open-addressing table with linear probing maps
// (cell id, key) to a bitmap in a word arena; a mark request finds or
// allocates the entry and sets one bit, a read request returns one arena word.
// after reset the slot status memory is swept clear, one slot a cycle, and no
// request is taken until the sweep is done.
// the front takes one request at a time: a mark request is held while the home
// slot is computed on one shared 32x32 multiplier and then handed into the
// queue, held until the queue takes it; a read request skips the hash.
// the back takes a request in its idle state, then for each slot probed issues
// a registered table read and checks it, clears the bitmap words of a new
// entry one by one, and does the bitmap read-modify-write on the arena.
// a mark that hits its home slot passes the back through probe issue, probe
// check, bit issue and bit data; with back-to-back marks of that kind the front
// sets the pace, the next hash overlapping the back through the two-entry
// queue. a read request passes the back through read issue and read data.
// results sit in an output register, and a stalled result holds the back.
module hash_bitmap_mark_insert_core import hbm_pkg::*; #(
  parameter int HASH_SLOTS   = 4096,
  parameter int ARENA_WORDS  = 65536,
  parameter int REFILL_WORDS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [23:0] cell_id_i,
  input  logic [63:0] key_value_i,
  input  logic [15:0] bit_rank_i,
  input  logic [16:0] bitmap_bits_i,
  input  logic [15:0] read_address_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        was_new_entry_o,
  output logic        bit_was_set_o,
  output logic [15:0] bitmap_offset_o,
  output logic [63:0] read_data_o
);

  localparam int SLOT_W = $clog2(HASH_SLOTS);
  localparam int QW     = $bits(req_t) + SLOT_W;

  // configuration registers
  logic [3:0]  hash_log2_q;
  logic [16:0] reserve_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_log2_q <= 4'd12;
      reserve_q   <= 17'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HASH_LOG2: hash_log2_q <= cfg_wdata_i[3:0];
        CFG_RESERVE:   reserve_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  req_t              in_req, f_req, b_req;
  logic [SLOT_W-1:0] f_slot, b_slot;
  logic              f_valid, f_ready, b_valid, b_ready, init_busy;
  logic [QW-1:0]     q_out;

  assign in_req = '{op: op_i, cell_id: cell_id_i, key_value: key_value_i,
                    bit_rank: bit_rank_i, bitmap_bits: bitmap_bits_i,
                    read_address: read_address_i};

  // front: request intake and home slot hash
  hbm_front #(.SLOT_W(SLOT_W)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_req_i(in_req),
    .init_busy_i(init_busy), .hash_log2_i(hash_log2_q),
    .push_valid_o(f_valid), .push_ready_i(f_ready),
    .push_req_o(f_req), .push_slot_o(f_slot)
  );

  // short queue so front and back stall on their own
  hbm_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_data_i({f_req, f_slot}),
    .pop_valid_o(b_valid), .pop_ready_i(b_ready), .pop_data_o(q_out)
  );

  assign b_req  = q_out[QW-1:SLOT_W];
  assign b_slot = q_out[SLOT_W-1:0];

  // back: probe, allocate, clear, set bit
  hbm_back #(
    .HASH_SLOTS(HASH_SLOTS), .ARENA_WORDS(ARENA_WORDS),
    .REFILL_WORDS(REFILL_WORDS), .SLOT_W(SLOT_W)
  ) u_back (
    .clk_i, .rst_ni,
    .pop_valid_i(b_valid), .pop_ready_o(b_ready),
    .pop_req_i(b_req), .pop_slot_i(b_slot),
    .hash_log2_i(hash_log2_q), .reserve_i(reserve_q),
    .init_busy_o(init_busy),
    .out_valid_o, .out_ready_i, .status_o, .was_new_entry_o,
    .bit_was_set_o, .bitmap_offset_o, .read_data_o
  );

endmodule

### hw/rtl/hbm_front.sv
// front end: takes requests and computes the home slot with one shared multiplier
module hbm_front import hbm_pkg::*; #(
  parameter int SLOT_W = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_req_i,
  input  logic              init_busy_i,
  input  logic [3:0]        hash_log2_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output req_t              push_req_o,
  output logic [SLOT_W-1:0] push_slot_o
);

  localparam logic [2:0] STEP_CA_LO = 3'd0;
  localparam logic [2:0] STEP_CA_HI = 3'd1;
  localparam logic [2:0] STEP_XB_LL = 3'd2;
  localparam logic [2:0] STEP_XB_LH = 3'd3;
  localparam logic [2:0] STEP_XB_HL = 3'd4;
  localparam logic [2:0] STEP_DONE  = 3'd5;

  logic        busy_q, busy_d;
  logic [2:0]  step_q, step_d;
  req_t        req_q, req_d;
  logic [63:0] x_q, x_d, acc_q, acc_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [4:0]  bits;
  logic [6:0]  shamt;

  always_comb begin
    mul_a = {8'd0, req_q.cell_id};
    mul_b = GOLD_A[31:0];
    case (step_q)
      STEP_CA_LO: begin mul_a = {8'd0, req_q.cell_id}; mul_b = GOLD_A[31:0]; end
      STEP_CA_HI: begin mul_a = {8'd0, req_q.cell_id}; mul_b = GOLD_A[63:32]; end
      STEP_XB_LL: begin mul_a = x_q[31:0];  mul_b = GOLD_B[31:0]; end
      STEP_XB_LH: begin mul_a = x_q[31:0];  mul_b = GOLD_B[63:32]; end
      STEP_XB_HL: begin mul_a = x_q[63:32]; mul_b = GOLD_B[31:0]; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  assign in_ready_o   = !busy_q && !init_busy_i;
  assign push_valid_o = busy_q && (step_q == STEP_DONE);
  assign push_req_o   = req_q;

  assign bits        = table_bits(hash_log2_i, 5'(SLOT_W));
  assign shamt       = 7'd64 - 7'(bits);
  assign push_slot_o = SLOT_W'(acc_q >> shamt);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    req_d  = req_q;
    x_d    = x_q;
    acc_d  = acc_q;
    if (in_valid_i && in_ready_o) begin
      busy_d = 1'b1;
      req_d  = in_req_i;
      step_d = (in_req_i.op == OP_READ) ? STEP_DONE : STEP_CA_LO;
    end else if (busy_q) begin
      case (step_q)
        STEP_CA_LO: begin acc_d = prod; step_d = STEP_CA_HI; end
        STEP_CA_HI: begin
          x_d    = req_q.key_value ^ (acc_q + {prod[31:0], 32'd0});
          step_d = STEP_XB_LL;
        end
        STEP_XB_LL: begin acc_d = prod; step_d = STEP_XB_LH; end
        STEP_XB_LH: begin acc_d = acc_q + {prod[31:0], 32'd0}; step_d = STEP_XB_HL; end
        STEP_XB_HL: begin acc_d = acc_q + {prod[31:0], 32'd0}; step_d = STEP_DONE; end
        STEP_DONE: begin
          if (push_ready_i) busy_d = 1'b0;
        end
        default: step_d = STEP_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_DONE;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    x_q   <= x_d;
    acc_q <= acc_d;
  end

endmodule

### hw/rtl/hbm_queue.sv
// two-entry queue between front and back
module hbm_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

### hw/rtl/hbm_back.sv
// back end: table probe, allocation, bitmap clear and bit update
module hbm_back import hbm_pkg::*; #(
  parameter int HASH_SLOTS   = 4096,
  parameter int ARENA_WORDS  = 65536,
  parameter int REFILL_WORDS = 512,
  parameter int SLOT_W       = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  req_t              pop_req_i,
  input  logic [SLOT_W-1:0] pop_slot_i,
  input  logic [3:0]        hash_log2_i,
  input  logic [16:0]       reserve_i,
  output logic              init_busy_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic              was_new_entry_o,
  output logic              bit_was_set_o,
  output logic [15:0]       bitmap_offset_o,
  output logic [63:0]       read_data_o
);

  localparam int ARENA_W = $clog2(ARENA_WORDS);
  localparam int CUR_W   = (ARENA_W + 4 > 18) ? ARENA_W + 4 : 18;

  localparam logic [2:0] B_IDLE      = 3'd0;
  localparam logic [2:0] B_RD_ISSUE  = 3'd1;
  localparam logic [2:0] B_RD_DATA   = 3'd2;
  localparam logic [2:0] B_PR_ISSUE  = 3'd3;
  localparam logic [2:0] B_PR_CHECK  = 3'd4;
  localparam logic [2:0] B_CLEAR     = 3'd5;
  localparam logic [2:0] B_BIT_ISSUE = 3'd6;
  localparam logic [2:0] B_BIT_DATA  = 3'd7;

  logic [1:0]         st_mem   [HASH_SLOTS];
  logic [23:0]        cell_mem [HASH_SLOTS];
  logic [63:0]        key_mem  [HASH_SLOTS];
  logic [ARENA_W-1:0] off_mem  [HASH_SLOTS];
  logic [63:0]        arena    [ARENA_WORDS];

  logic [1:0]         st_rd_q;
  logic [23:0]        cell_rd_q;
  logic [63:0]        key_rd_q;
  logic [ARENA_W-1:0] off_rd_q;
  logic [63:0]        ar_rd_q;

  logic [2:0]         state_q, state_d;
  req_t               req_q, req_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [SLOT_W:0]    probes_q, probes_d;
  logic [CUR_W-1:0]   off_q, off_d;
  logic               fresh_q, fresh_d;
  logic [WORDS_W-1:0] words_q, words_d, clr_q, clr_d;
  logic               ovf_q, ovf_d;
  logic [CUR_W-1:0]   gcur_q, gcur_d, cnext_q, cnext_d, cend_q, cend_d;
  logic               init_q;
  logic [SLOT_W-1:0]  icnt_q;

  logic               ov_q, ov_d;
  logic [1:0]         ost_q, ost_d;
  logic               onew_q, onew_d, oset_q, oset_d;
  logic [15:0]        ooff_q, ooff_d;
  logic [63:0]        odat_q, odat_d;

  logic               st_we, slot_we;
  logic [SLOT_W-1:0]  st_wa;
  logic [1:0]         st_wd;
  logic               ar_we;
  logic [ARENA_W-1:0] ar_wa, ar_ra, bit_addr;
  logic [63:0]        ar_wd, mask;

  logic [4:0]         bits;
  logic [SLOT_W:0]    capv;
  logic [SLOT_W-1:0]  cap_mask;
  logic [WORDS_W-1:0] words_c;
  logic [CUR_W-1:0]   wext, chunk, gend, res_ext, res_eff;
  logic               fit, fail, out_free;

  assign init_busy_o = init_q;
  assign out_free    = !ov_q || out_ready_i;
  assign pop_ready_o = (state_q == B_IDLE) && !init_q && out_free;

  assign bits     = table_bits(hash_log2_i, 5'(SLOT_W));
  assign capv     = (SLOT_W + 1)'(1) << bits;
  assign cap_mask = SLOT_W'(capv - (SLOT_W + 1)'(1));

  assign words_c = WORDS_W'(({1'b0, req_q.bitmap_bits} + 18'd63) >> 6);
  assign wext    = CUR_W'(words_c);
  assign fit     = (cnext_q + wext) <= cend_q;
  assign chunk   = (wext > CUR_W'(REFILL_WORDS)) ? wext : CUR_W'(REFILL_WORDS);
  assign gend    = gcur_q + chunk;
  assign res_ext = CUR_W'(reserve_i);
  assign res_eff = (res_ext > CUR_W'(ARENA_WORDS)) ? CUR_W'(ARENA_WORDS) : res_ext;
  assign fail    = gend > res_eff;

  assign bit_addr = ARENA_W'(off_q + CUR_W'(req_q.bit_rank >> 6));
  assign mask     = 64'd1 << req_q.bit_rank[5:0];
  assign ar_ra    = (state_q == B_RD_ISSUE) ? ARENA_W'(req_q.read_address) : bit_addr;

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    slot_d   = slot_q;
    probes_d = probes_q;
    off_d    = off_q;
    fresh_d  = fresh_q;
    words_d  = words_q;
    clr_d    = clr_q;
    ovf_d    = ovf_q;
    gcur_d   = gcur_q;
    cnext_d  = cnext_q;
    cend_d   = cend_q;
    ov_d     = ov_q && !out_ready_i;
    ost_d    = ost_q;
    onew_d   = onew_q;
    oset_d   = oset_q;
    ooff_d   = ooff_q;
    odat_d   = odat_q;
    st_we    = 1'b0;
    st_wa    = slot_q;
    st_wd    = SLOT_EMPTY;
    slot_we  = 1'b0;
    ar_we    = 1'b0;
    ar_wa    = bit_addr;
    ar_wd    = ar_rd_q | mask;

    case (state_q)
      B_IDLE: begin
        if (pop_valid_i && pop_ready_o) begin
          req_d    = pop_req_i;
          slot_d   = pop_slot_i;
          probes_d = '0;
          fresh_d  = 1'b0;
          if (pop_req_i.op == OP_READ) begin
            state_d = B_RD_ISSUE;
          end else if (ovf_q) begin
            ov_d   = 1'b1;
            ost_d  = ST_DROPPED;
            onew_d = 1'b0;
            oset_d = 1'b0;
            ooff_d = 16'd0;
            odat_d = 64'd0;
          end else begin
            state_d = B_PR_ISSUE;
          end
        end
      end
      B_RD_ISSUE: state_d = B_RD_DATA;
      B_RD_DATA: begin
        ov_d    = 1'b1;
        ost_d   = ST_DONE;
        onew_d  = 1'b0;
        oset_d  = 1'b0;
        ooff_d  = 16'd0;
        odat_d  = ar_rd_q;
        state_d = B_IDLE;
      end
      B_PR_ISSUE: state_d = B_PR_CHECK;
      B_PR_CHECK: begin
        if (st_rd_q == SLOT_FILLED && cell_rd_q == req_q.cell_id
            && key_rd_q == req_q.key_value) begin
          off_d   = CUR_W'(off_rd_q);
          state_d = B_BIT_ISSUE;
        end else if (st_rd_q == SLOT_EMPTY) begin
          st_we   = 1'b1;
          words_d = words_c;
          clr_d   = '0;
          if (fit) begin
            off_d   = cnext_q;
            cnext_d = cnext_q + wext;
          end else begin
            gcur_d = gend;
            if (!fail) begin
              off_d   = gcur_q;
              cnext_d = gcur_q + wext;
              cend_d  = gend;
            end
          end
          if (!fit && fail) begin
            st_wd   = SLOT_CLAIMED;
            ovf_d   = 1'b1;
            ov_d    = 1'b1;
            ost_d   = ST_OVERFLOW;
            onew_d  = 1'b0;
            oset_d  = 1'b0;
            ooff_d  = 16'd0;
            odat_d  = 64'd0;
            state_d = B_IDLE;
          end else begin
            st_wd   = SLOT_FILLED;
            slot_we = 1'b1;
            fresh_d = 1'b1;
            state_d = (words_c == '0) ? B_BIT_ISSUE : B_CLEAR;
          end
        end else begin
          slot_d   = (slot_q + SLOT_W'(1)) & cap_mask;
          probes_d = probes_q + (SLOT_W + 1)'(1);
          if (probes_d >= capv) begin
            ovf_d   = 1'b1;
            ov_d    = 1'b1;
            ost_d   = ST_OVERFLOW;
            onew_d  = 1'b0;
            oset_d  = 1'b0;
            ooff_d  = 16'd0;
            odat_d  = 64'd0;
            state_d = B_IDLE;
          end else begin
            state_d = B_PR_ISSUE;
          end
        end
      end
      B_CLEAR: begin
        ar_we = 1'b1;
        ar_wa = ARENA_W'(off_q + CUR_W'(clr_q));
        ar_wd = 64'd0;
        clr_d = clr_q + WORDS_W'(1);
        if (clr_q == words_q - WORDS_W'(1)) state_d = B_BIT_ISSUE;
      end
      B_BIT_ISSUE: state_d = B_BIT_DATA;
      B_BIT_DATA: begin
        ar_we   = 1'b1;
        ov_d    = 1'b1;
        ost_d   = ST_DONE;
        onew_d  = fresh_q;
        oset_d  = (ar_rd_q & mask) != 64'd0;
        ooff_d  = 16'(off_q);
        odat_d  = 64'd0;
        state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase

    if (init_q) begin
      st_we = 1'b1;
      st_wa = icnt_q;
      st_wd = SLOT_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ovf_q   <= 1'b0;
      gcur_q  <= '0;
      cnext_q <= '0;
      cend_q  <= '0;
      init_q  <= 1'b1;
      icnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
      gcur_q  <= gcur_d;
      cnext_q <= cnext_d;
      cend_q  <= cend_d;
      ov_q    <= ov_d;
      if (init_q) begin
        icnt_q <= icnt_q + SLOT_W'(1);
        if (icnt_q == '1) init_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    slot_q   <= slot_d;
    probes_q <= probes_d;
    off_q    <= off_d;
    fresh_q  <= fresh_d;
    words_q  <= words_d;
    clr_q    <= clr_d;
    ost_q    <= ost_d;
    onew_q   <= onew_d;
    oset_q   <= oset_d;
    ooff_q   <= ooff_d;
    odat_q   <= odat_d;
  end

  // slot table memories
  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    if (slot_we) begin
      cell_mem[slot_q] <= req_q.cell_id;
      key_mem[slot_q]  <= req_q.key_value;
      off_mem[slot_q]  <= ARENA_W'(off_d);
    end
    st_rd_q   <= st_mem[slot_q];
    cell_rd_q <= cell_mem[slot_q];
    key_rd_q  <= key_mem[slot_q];
    off_rd_q  <= off_mem[slot_q];
  end

  // bitmap arena
  always_ff @(posedge clk_i) begin
    if (ar_we) arena[ar_wa] <= ar_wd;
    ar_rd_q <= arena[ar_ra];
  end

  assign out_valid_o     = ov_q;
  assign status_o        = ost_q;
  assign was_new_entry_o = onew_q;
  assign bit_was_set_o   = oset_q;
  assign bitmap_offset_o = ooff_q;
  assign read_data_o     = odat_q;

endmodule

### hw/rtl/hbm_checker.sv
// port-level checker of the hash bitmap mark/insert block, with its bind
`include "hash_bitmap_mark_insert_core_assert.svh"

module hbm_checker import hbm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic        was_new_entry_o,
  input logic        bit_was_set_o,
  input logic [15:0] bitmap_offset_o,
  input logic [63:0] read_data_o
);

  `HBM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `HBM_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(read_data_o) && $stable(status_o), "stalled result changed")
  `HBM_ASSERT_NOW(a_fail_zero, out_valid_o && status_o != ST_DONE, !was_new_entry_o && !bit_was_set_o && bitmap_offset_o == 16'd0 && read_data_o == 64'd0, "failed request carries data")
  `HBM_ASSERT_NOW(a_new_is_mark, out_valid_o && was_new_entry_o, status_o == ST_DONE && read_data_o == 64'd0, "new entry on a non-mark result")

endmodule

bind hash_bitmap_mark_insert_core hbm_checker u_hbm_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .status_o, .was_new_entry_o,
  .bit_was_set_o, .bitmap_offset_o, .read_data_o
);

### tb/tb_hash_bitmap_mark_insert_core.sv
// testbench for the hash bitmap mark/insert core: random and directed requests against a predictor
module tb_hash_bitmap_mark_insert_core;
  import hbm_pkg::*;

  localparam int          TABLE_SLOTS = 4096;
  localparam int          ARENA_SIZE  = 65536;
  localparam int          REFILL_SIZE = 512;
  localparam int          MAX_BITS    = 12;
  localparam logic [63:0] MIX         = 64'h9e3779b97f4a7c15;
  localparam logic [1:0]  CFG_SPARE   = 2'd3;  // index past the register list, ignored
  localparam int          CYCLE_LIMIT = 3_000_000;

  typedef enum int {LOOK_HIT, LOOK_EMPTY, LOOK_FULL} lookup_e;

  typedef struct packed {
    logic [1:0]  status;
    logic        fresh_entry;
    logic        bit_was_set;
    logic [15:0] offset;
    logic [63:0] read_data;
  } result_t;

  typedef struct packed {
    logic [23:0] cid;
    logic [63:0] key;
  } entry_key_t;

  // bit-exact model of the table, the allocator and the arena
  class mark_scoreboard;
    int unsigned    log2_reg = 12;
    int unsigned    reserve_reg = 65536;
    logic [1:0]     slot_state[TABLE_SLOTS];
    logic [23:0]    slot_cell[TABLE_SLOTS];
    logic [63:0]    slot_key[TABLE_SLOTS];
    logic [15:0]    slot_off[TABLE_SLOTS];
    logic [63:0]    arena[ARENA_SIZE];
    bit             written[ARENA_SIZE];
    int unsigned    written_list[$];
    longint unsigned cursor, chunk_next, chunk_stop;
    bit             overflowed;
    result_t        expected_q[$];
    int             errors, checked;
    int             n_new, n_hit, n_drop, n_over, n_read, n_already;

    function new();
      foreach (slot_state[i]) slot_state[i] = SLOT_EMPTY;
    endfunction

    function int unsigned eff_bits();
      if (log2_reg == 0) return 1;
      if (log2_reg > MAX_BITS) return MAX_BITS;
      return log2_reg;
    endfunction

    function longint unsigned eff_reserve();
      return (reserve_reg > ARENA_SIZE) ? ARENA_SIZE : reserve_reg;
    endfunction

    function lookup_e locate(logic [23:0] cid, logic [63:0] key, output int unsigned slot);
      logic [63:0] h;
      int unsigned b, cap;
      b = eff_bits();
      cap = 1 << b;
      h = (key ^ (64'(cid) * MIX)) * MIX;
      slot = int'(h >> (64 - b));
      for (int unsigned p = 0; p < cap; p++) begin
        if (slot_state[slot] == SLOT_FILLED && slot_cell[slot] == cid && slot_key[slot] == key)
          return LOOK_HIT;
        if (slot_state[slot] == SLOT_EMPTY) return LOOK_EMPTY;
        slot = (slot + 1) & (cap - 1);
      end
      return LOOK_FULL;
    endfunction

    function bit alloc_fits(longint unsigned words);
      longint unsigned chunk;
      if (chunk_next + words <= chunk_stop) return 1;
      chunk = (words > REFILL_SIZE) ? words : REFILL_SIZE;
      return cursor + chunk <= eff_reserve();
    endfunction

    // true when this mark would not raise overflow
    function bit mark_safe(logic [23:0] cid, logic [63:0] key, logic [16:0] nbits);
      int unsigned slot;
      lookup_e look;
      look = locate(cid, key, slot);
      if (look == LOOK_HIT) return 1;
      if (look == LOOK_FULL) return 0;
      return alloc_fits((longint'(nbits) + 63) >> 6);
    endfunction

    function void touch(int unsigned addr);
      arena[addr] = arena[addr];
      if (!written[addr]) begin
        written[addr] = 1;
        written_list.insert(written_list.size(), addr);
      end
    endfunction

    function void note_request(req_t r);
      result_t res;
      int unsigned slot, addr;
      longint unsigned words, chunk, offset;
      lookup_e look;
      logic [63:0] mask;
      res = '0;
      if (r.op == OP_READ) begin
        res.read_data = arena[r.read_address];
        n_read++;
      end else if (overflowed) begin
        res.status = ST_DROPPED;
        n_drop++;
      end else begin
        look = locate(r.cell_id, r.key_value, slot);
        if (look == LOOK_FULL) begin
          overflowed = 1;
          res.status = ST_OVERFLOW;
          n_over++;
        end else begin
          if (look == LOOK_HIT) begin
            offset = 64'(slot_off[slot]);
            n_hit++;
          end else begin
            words = (longint'(r.bitmap_bits) + 63) >> 6;
            slot_state[slot] = SLOT_CLAIMED;
            if (chunk_next + words <= chunk_stop) begin
              offset = chunk_next;
              chunk_next += words;
            end else begin
              chunk = (words > REFILL_SIZE) ? words : REFILL_SIZE;
              offset = cursor;
              cursor += chunk;
              if (offset + chunk > eff_reserve()) begin
                overflowed = 1;
              end else begin
                chunk_next = offset + words;
                chunk_stop = offset + chunk;
              end
            end
            if (overflowed) begin
              res.status = ST_OVERFLOW;
              n_over++;
            end else begin
              for (longint unsigned i = 0; i < words; i++) begin
                arena[offset + i] = '0;
                touch(int'(offset + i));
              end
              slot_cell[slot] = r.cell_id;
              slot_key[slot] = r.key_value;
              slot_off[slot] = offset[15:0];
              slot_state[slot] = SLOT_FILLED;
              res.fresh_entry = 1;
              n_new++;
            end
          end
          if (res.status == ST_DONE) begin
            addr = (int'(offset) + (r.bit_rank >> 6)) % ARENA_SIZE;
            mask = 64'd1 << r.bit_rank[5:0];
            res.bit_was_set = (arena[addr] & mask) != 0;
            if (res.bit_was_set) n_already++;
            arena[addr] |= mask;
            touch(addr);
            res.offset = offset[15:0];
          end
        end
      end
      expected_q.insert(expected_q.size(), res);
    endfunction

    function void check_result(result_t act);
      result_t exp_r;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing expected: status %0d", act.status);
        return;
      end
      exp_r = expected_q.pop_front();
      if (act !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on result %0d: exp st %0d new %0b set %0b off %0h data %h, got st %0d new %0b set %0b off %0h data %h",
                   checked, exp_r.status, exp_r.fresh_entry, exp_r.bit_was_set, exp_r.offset,
                   exp_r.read_data, act.status, act.fresh_entry, act.bit_was_set, act.offset,
                   act.read_data);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [16:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        op_i = 1'b0;
  logic [23:0] cell_id_i = '0;
  logic [63:0] key_value_i = '0;
  logic [15:0] bit_rank_i = '0;
  logic [16:0] bitmap_bits_i = '0;
  logic [15:0] read_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic        was_new_entry_o;
  logic        bit_was_set_o;
  logic [15:0] bitmap_offset_o;
  logic [63:0] read_data_o;

  mark_scoreboard sb = new();
  entry_key_t     key_pool[$];
  bit             send_free;      // stretch with no sender gaps
  bit             drain_free;     // stretch with no receiver stalls
  int             stall_left;
  int             cycles;

  hash_bitmap_mark_insert_core i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("hash_bitmap_mark_insert_core verification failed");
      $finish;
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({status_o, was_new_entry_o, bit_was_set_o, bitmap_offset_o, read_data_o});
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver backpressure, switching between free-running and stalling stretches
  always @(negedge clk_i) begin
    if (cycles % 300 == 0) drain_free <= $urandom_range(3) == 0;
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!drain_free && $urandom_range(2) == 0) stall_left <= pick_gap();
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [16:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    if (idx == CFG_HASH_LOG2) sb.log2_reg = 32'(value[3:0]);
    else if (idx == CFG_RESERVE) sb.reserve_reg = 32'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // present one request and hold it until accepted
  task automatic send_request(req_t r);
    int gap;
    gap = send_free ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    op_i <= r.op;
    cell_id_i <= r.cell_id;
    key_value_i <= r.key_value;
    bit_rank_i <= r.bit_rank;
    bitmap_bits_i <= r.bitmap_bits;
    read_address_i <= r.read_address;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    if (r.op == OP_MARK && key_pool.size() < 4096)
      key_pool.insert(key_pool.size(), entry_key_t'({r.cell_id, r.key_value}));
  endtask

  // hold off until every outstanding result is back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic req_t read_req();
    req_t r;
    r = '0;
    r.op = OP_READ;
    r.cell_id = 24'($urandom);
    r.key_value = {$urandom, $urandom};
    r.read_address = 16'(sb.written_list[$urandom_range(sb.written_list.size() - 1)]);
    return r;
  endfunction

  function automatic req_t mark_req(logic [23:0] cid, logic [63:0] key, logic [16:0] nbits,
                                    logic [15:0] rank);
    req_t r;
    r.op = OP_MARK;
    r.cell_id = cid;
    r.key_value = key;
    r.bitmap_bits = nbits;
    r.bit_rank = rank;
    r.read_address = 16'($urandom);
    return r;
  endfunction

  function automatic req_t random_mark();
    entry_key_t k;
    logic [16:0] nbits;
    logic [15:0] rank;
    int r;
    r = $urandom_range(99);
    if (key_pool.size() > 0 && r < 50) begin
      k = key_pool[$urandom_range(key_pool.size() - 1)];
    end else begin
      k.cid = 24'($urandom);
      k.key = {$urandom, $urandom};
      if (r > 95) k.cid = '1;
      else if (r > 91) k.cid = '0;
    end
    r = $urandom_range(99);
    if (r < 70) nbits = 17'($urandom_range(1, 256));
    else if (r < 93) nbits = 17'($urandom_range(0, 1024));
    else if (r < 96) nbits = '0;
    else nbits = 17'($urandom_range(65536, 131071));
    if ($urandom_range(4) == 0) rank = 16'($urandom);
    else rank = 16'($urandom_range(0, (nbits > 0) ? nbits - 1 : 0));
    return mark_req(k.cid, k.key, nbits, rank);
  endfunction

  // one random request that never raises overflow
  task automatic random_safe_request();
    req_t r;
    r = random_mark();
    if ($urandom_range(3) == 0 || !sb.mark_safe(r.cell_id, r.key_value, r.bitmap_bits))
      r = read_req();
    send_request(r);
  endtask

  initial begin
    int unsigned log2_set[5] = '{0, 15, 3, 12, 7};
    int unsigned resv_set[5] = '{131071, 65536, 60000, 0, 65536};
    req_t r;
    int tail;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every register and the unused index, while the block sweeps its table
    write_reg(CFG_SPARE, 17'h1ffff);
    write_reg(CFG_HASH_LOG2, 17'h1fffc);  // upper bits dropped, leaves 12
    write_reg(CFG_RESERVE, 17'd65536);

    // directed: field extremes, zero length, huge bitmaps, rank past the bitmap, repeats
    send_request(mark_req('0, '0, 17'd1, 16'd0));
    send_request(mark_req('0, '0, 17'd1, 16'd0));
    send_request(mark_req('1, '1, 17'd64, 16'd63));
    send_request(mark_req('1, '1, 17'd64, 16'hffff));
    send_request(mark_req(24'h5a5a5a, 64'h0123456789abcdef, 17'd0, 16'd5));
    send_request(mark_req(24'h5a5a5a, 64'h0123456789abcdef, 17'd0, 16'd5));
    send_request(mark_req(24'h000001, 64'd1, 17'd65, 16'd64));
    for (int i = 0; i < 16; i++)
      send_request(mark_req(24'(i), 64'hfedc_0000_0000_0000 | 64'(i),
                            (i % 2) ? 17'd131071 : 17'd65536, 16'hffff - 16'(i)));
    send_free = 1;
    send_request(read_req());
    send_request(read_req());
    send_free = 0;
    drain();

    // settings phases, several extremes among them
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_HASH_LOG2, 17'(log2_set[ph]));
      write_reg(CFG_RESERVE, 17'(resv_set[ph]));
      for (int n = 0; n < 280; n++) begin
        if (n % 70 == 0) send_free = $urandom_range(2) == 0;
        if (ph == 2 && n == 140) drain();  // pause mid-phase until all results are in
        random_safe_request();
      end
      send_free = 0;
      drain();
    end

    // raise overflow, either by filling a tiny table or by running out of arena
    if ($urandom_range(1)) begin
      write_reg(CFG_HASH_LOG2, 17'd1);
      write_reg(CFG_RESERVE, 17'd65536);
      while (!sb.overflowed)
        send_request(mark_req(24'($urandom), {$urandom, $urandom}, 17'd64, 16'd1));
    end else begin
      write_reg(CFG_HASH_LOG2, 17'd12);
      write_reg(CFG_RESERVE, 17'(sb.cursor));
      while (!sb.overflowed)
        send_request(mark_req(24'($urandom), {$urandom, $urandom},
                              17'($urandom_range(64, 4096)), 16'd3));
    end
    // dropped marks and reads that are still served
    for (tail = 0; tail < 40; tail++) begin
      if ($urandom_range(1)) r = random_mark();
      else r = read_req();
      send_request(r);
    end
    drain();
    repeat (50) @(posedge clk_i);

    $display("covered %0d new entries, %0d hits, %0d already-set bits, %0d reads",
             sb.n_new, sb.n_hit, sb.n_already, sb.n_read);
    $display("overflow raised %0d time(s), %0d marks dropped, %0d results checked",
             sb.n_over, sb.n_drop, sb.checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("hash_bitmap_mark_insert_core verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
      $display("hash_bitmap_mark_insert_core verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/hbm_pkg.sv
hw/rtl/hbm_front.sv
hw/rtl/hbm_queue.sv
hw/rtl/hbm_back.sv
hw/rtl/hash_bitmap_mark_insert_core.sv
hw/rtl/hbm_checker.sv
tb/tb_hash_bitmap_mark_insert_core.sv
